>>> rtl/core/assert_macros.svh
// Assertion helpers. Both use the enclosing module's clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/crpm_pkg.sv
`timescale 1ns / 1ps

package crpm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 16;
    localparam int SQ_W       = 31;
    localparam int BSUM_W     = 39;
    localparam int RSUM_W     = 62;
    localparam int CNT_W      = 32;
    localparam int LEN_W      = 9;
    localparam int POS_W      = 8;
    localparam int LEVEL_W    = 16;
    localparam int REM_W      = 33;
    localparam int SUB_W      = 34;
    localparam int ITER_W     = 6;
    localparam int DIV_STEPS  = 62;
    localparam int SQRT_STEPS = 16;
    localparam int MAX_BLOCK  = 256;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = 9'd128;

    // register index, taken from paddr[2]
    localparam logic REG_BLOCK_LENGTH = 1'b0;

    typedef logic [LEN_W-1:0] len_t;
    typedef logic [CNT_W-1:0] count_t;

    // zero reads as one, anything above MAX_BLOCK clamps
    function automatic len_t eff_len(input len_t raw);
        len_t r;
        r = raw;
        if (raw == '0)
            r = len_t'(1);
        else if (raw > len_t'(MAX_BLOCK))
            r = len_t'(MAX_BLOCK);
        return r;
    endfunction

endpackage

>>> rtl/core/cumulative_rms_peak_meter_core.sv
// A sample that does not end a block frees the input once it is squared and accumulated.
// A block-ending sample goes on: square, accumulate, a 62-step mean divide, update, a 62-step
// Leq divide and a 16-step square root in one shared subtract unit, then a load of the output
// register; a zero running sum skips the Leq divide and square root. No new sample is taken
// until the output register is loaded, so a result stall also holds the input. Reset (rst_n,
// async, low) clears all sums, counts and peak, sets the cumulative flag high (cumulative_ok
// takes it at the next result load) and sets block_length to 128.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cumulative_rms_peak_meter_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // config port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [crpm_pkg::APB_AW-1:0]          paddr,
    input  logic [crpm_pkg::APB_DW-1:0]          pwdata,
    output logic [crpm_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready,
    // sample channel
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic signed [crpm_pkg::SAMPLE_W-1:0] sample,
    // result channel
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [crpm_pkg::LEVEL_W-1:0]         rms_level,
    output logic                                 rms_ok,
    output logic                                 cumulative_ok,
    output logic [crpm_pkg::LEVEL_W-1:0]         peak_mag
);
    import crpm_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;  // square the magnitude, track peak
    localparam logic [2:0] S_ACC  = 3'd2;  // add to block sum, test block end
    localparam logic [2:0] S_DIV1 = 3'd3;  // block sum / samples taken
    localparam logic [2:0] S_UPD  = 3'd4;  // fold mean into running sum
    localparam logic [2:0] S_DIV2 = 3'd5;  // running sum / block count
    localparam logic [2:0] S_SQRT = 3'd6;  // floor sqrt of that quotient
    localparam logic [2:0] S_OUT  = 3'd7;  // wait for the output register

    logic [2:0]          state_reg;
    len_t                len_reg;
    logic [MAG_W-1:0]    peak_reg;
    logic [BSUM_W-1:0]   bsum_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [RSUM_W-1:0]   rsum_reg;
    count_t              cnt_reg;
    logic                flag_reg;
    logic                rv_reg;

    // datapath, no reset
    logic [MAG_W-1:0]    mag_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [RSUM_W-1:0]   q_reg;
    count_t              div_reg;
    logic [LEVEL_W-1:0]  root_reg;
    logic [ITER_W-1:0]   iter_reg;
    logic [LEVEL_W-1:0]  lvl_reg;
    logic                ok_reg;
    logic                cum_reg;
    logic [LEVEL_W-1:0]  pk_reg;

    logic [MAG_W-1:0]    sample_u;
    logic [MAG_W-1:0]    mag;
    logic [2*MAG_W-1:0]  sq_full;
    logic [BSUM_W-1:0]   bsum_sum;
    len_t                taken;
    logic                blk_end;
    logic                cfg_wr;
    logic                out_free;
    logic [SUB_W-1:0]    sub_a;
    logic [SUB_W-1:0]    sub_b;
    logic [SUB_W:0]      sub_diff;
    logic                geq;
    logic [REM_W-1:0]    rem_step;
    logic                cnt_full;
    logic [RSUM_W-1:0]   rsum_new;
    count_t              cnt_new;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_BLOCK_LENGTH) ? APB_DW'(len_reg) : '0;

    // ---------------- handshakes ----------------
    // only idle takes a sample; the output register parts the two sides
    assign sample_stall = (state_reg != S_IDLE);
    assign out_free     = !rv_reg || !result_stall;

    assign result_valid  = rv_reg;
    assign rms_level     = lvl_reg;
    assign rms_ok        = ok_reg;
    assign cumulative_ok = cum_reg;
    assign peak_mag      = pk_reg;

    // ---------------- per-sample arithmetic ----------------
    // two's complement magnitude; -1.0 gives 0x8000 = 32768
    assign sample_u = sample;
    assign mag      = sample_u[MAG_W-1] ? (~sample_u + MAG_W'(1)) : sample_u;
    assign sq_full  = (2*MAG_W)'(mag_reg) * (2*MAG_W)'(mag_reg);
    assign bsum_sum = bsum_reg + BSUM_W'(sq_reg);
    assign taken    = len_t'(pos_reg) + len_t'(1);
    // a length cut below the current count ends the block on the next sample
    assign blk_end  = (taken >= eff_len(len_reg));

    // ---------------- shared subtract unit ----------------
    // Divide: restoring shift-subtract, one quotient bit per cycle.
    // Sqrt: digit recurrence, trial = {root, 01}, two radicand bits per cycle.
    always_comb
    begin
        case (state_reg)
            S_SQRT:
            begin
                sub_a = {rem_reg[REM_W-2:0], q_reg[31:30]};
                sub_b = SUB_W'({root_reg, 2'b01});
            end
            default:
            begin
                sub_a = {rem_reg, q_reg[RSUM_W-1]};
                sub_b = SUB_W'(div_reg);
            end
        endcase
        sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
        geq      = !sub_diff[SUB_W];
        rem_step = geq ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];
    end

    // block-end fold; a saturated count restarts the average
    assign cnt_full = (cnt_reg == '1);
    assign rsum_new = cnt_full ? '0 : (rsum_reg + RSUM_W'(q_reg[SQ_W-1:0]));
    assign cnt_new  = cnt_full ? count_t'(1) : (cnt_reg + count_t'(1));

    // ---------------- control and state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= LEN_RESET;
            peak_reg  <= '0;
            bsum_reg  <= '0;
            pos_reg   <= '0;
            rsum_reg  <= '0;
            cnt_reg   <= '0;
            flag_reg  <= 1'b1;
            rv_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr && (paddr[2] == REG_BLOCK_LENGTH))
                len_reg <= pwdata[LEN_W-1:0];

            // set on a load, cleared once the consumer takes the result
            if ((state_reg == S_OUT) && out_free)
                rv_reg <= 1'b1;
            else if (rv_reg && !result_stall)
                rv_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (sample_valid)
                        state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    if (mag_reg > peak_reg)
                        peak_reg <= mag_reg;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (blk_end)
                    begin
                        bsum_reg  <= '0;
                        pos_reg   <= '0;
                        state_reg <= S_DIV1;
                    end
                    else
                    begin
                        bsum_reg  <= bsum_sum;
                        pos_reg   <= pos_reg + POS_W'(1);
                        state_reg <= S_IDLE;
                    end
                end
                S_DIV1:
                begin
                    if (iter_reg == ITER_W'(DIV_STEPS - 1))
                        state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    rsum_reg <= rsum_new;
                    cnt_reg  <= cnt_new;
                    if (cnt_full)
                        flag_reg <= 1'b0;
                    // zero sum: level is zero, no divide needed
                    state_reg <= (rsum_new != '0) ? S_DIV2 : S_OUT;
                end
                S_DIV2:
                begin
                    if (iter_reg == ITER_W'(DIV_STEPS - 1))
                        state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (iter_reg == ITER_W'(SQRT_STEPS - 1))
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                    mag_reg <= mag;
            end
            S_SQ:
                sq_reg <= sq_full[SQ_W-1:0];
            S_ACC:
            begin
                q_reg    <= RSUM_W'(bsum_sum);
                rem_reg  <= '0;
                div_reg  <= count_t'(taken);
                iter_reg <= '0;
            end
            S_DIV1, S_DIV2:
            begin
                q_reg <= {q_reg[RSUM_W-2:0], geq};
                if (iter_reg == ITER_W'(DIV_STEPS - 1))
                begin
                    iter_reg <= '0;
                    if (state_reg == S_DIV2)
                    begin
                        rem_reg  <= '0;
                        root_reg <= '0;
                    end
                    else
                        rem_reg <= rem_step;
                end
                else
                begin
                    rem_reg  <= rem_step;
                    iter_reg <= iter_reg + ITER_W'(1);
                end
            end
            S_UPD:
            begin
                q_reg    <= rsum_new;
                rem_reg  <= '0;
                div_reg  <= cnt_new;
                iter_reg <= '0;
                root_reg <= '0;
            end
            S_SQRT:
            begin
                rem_reg  <= rem_step;
                root_reg <= {root_reg[LEVEL_W-2:0], geq};
                q_reg    <= {q_reg[RSUM_W-3:0], 2'b00};
                iter_reg <= iter_reg + ITER_W'(1);
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    lvl_reg <= root_reg;
                    ok_reg  <= (rsum_reg != '0);
                    cum_reg <= flag_reg;
                    pk_reg  <= peak_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- assertions ----------------
    // an invalid level must read as zero
    `ASSERT_IMP(a_level_zero_when_invalid, result_valid && !rms_ok, rms_level == '0)
    // block mean never exceeds a full-scale square
    `ASSERT_IMP(a_mean_in_range, state_reg == S_UPD, q_reg[RSUM_W-1:SQ_W] == '0)
    // Leq divide never sees a zero count
    `ASSERT_IMP(a_div2_nonzero, state_reg == S_DIV2, div_reg != '0)
    // a loaded result carries the current flag
    `ASSERT_NEXT(a_out_load, state_reg == S_OUT && out_free, result_valid && (cumulative_ok == flag_reg))

endmodule
